// File: rtl/modular_exponentiation_unit_assert.svh
// Assertion macros for the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define MEU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define MEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

    localparam int unsigned MEXP_WIDTH_DEF = 64;

    typedef enum logic [1:0] {
        MM_REDUCE,
        MM_MUL,
        MM_SQR
    } t_mm_op;

    typedef struct packed {
        logic   load;
        logic   start;
        t_mm_op op;
        logic   shift_exp;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_zero;
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
    } t_dp_stat;

endpackage

// File: rtl/mexp_dp.sv
// Datapath: operand registers and bit-serial modular multiplier.
module mexp_dp #(
    parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mexp_pkg::t_dp_cmd  i_cmd,
    output mexp_pkg::t_dp_stat o_stat,
    input  logic [WIDTH-1:0]   i_base_value,
    input  logic [WIDTH-1:0]   i_exponent,
    input  logic [WIDTH-1:0]   i_modulus,
    output logic [WIDTH-1:0]   o_power_result
);
    import mexp_pkg::*;

    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_mm_a;
    logic [WIDTH-1:0] r_mm_b;
    logic [WIDTH-1:0] r_mm_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    t_mm_op           r_op;

    logic [WIDTH-1:0] w_a_raw;
    logic [WIDTH-1:0] w_a;
    logic [WIDTH-1:0] w_dbl;
    logic [WIDTH-1:0] w_step;
    logic             w_last;

    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    always_comb begin
        case (i_cmd.op)
            MM_REDUCE: w_a_raw = WIDTH'(1);
            MM_MUL:    w_a_raw = r_acc;
            MM_SQR:    w_a_raw = r_base;
            default:   w_a_raw = '0;
        endcase
    end

    // reduce the left operand: only 1 mod 1 needs it
    assign w_a    = (r_mod == WIDTH'(1)) ? '0 : w_a_raw;
    assign w_dbl  = add_mod(r_mm_acc, r_mm_acc, r_mod);
    assign w_step = r_mm_b[WIDTH-1] ? add_mod(w_dbl, r_mm_a, r_mod) : w_dbl;
    assign w_last = r_busy && (r_cnt == CW'(WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
        end else if (w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= i_base_value;
            r_exp  <= i_exponent;
            r_mod  <= i_modulus;
            r_acc  <= WIDTH'(1);
        end else begin
            if (i_cmd.shift_exp) begin
                r_exp <= r_exp >> 1;
            end
            if (w_last) begin
                case (r_op)
                    MM_MUL:  r_acc  <= w_step;
                    default: r_base <= w_step;
                endcase
            end
        end
        if (i_cmd.start) begin
            r_mm_a   <= w_a;
            r_mm_b   <= r_base;
            r_mm_acc <= '0;
            r_cnt    <= '0;
            r_op     <= i_cmd.op;
        end else if (r_busy) begin
            r_mm_acc <= w_step;
            r_mm_b   <= r_mm_b << 1;
            r_cnt    <= r_cnt + CW'(1);
        end
    end

    assign o_stat.mod_zero = (r_mod == '0);
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_lsb  = r_exp[0];
    assign o_stat.mul_done = w_last;
    assign o_power_result  = r_acc;

endmodule

// File: rtl/mexp_ctrl.sv
// Controller: sequences reduction, multiply and square passes.
module mexp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_free,
    output logic               o_finish,
    output mexp_pkg::t_dp_cmd  o_cmd,
    input  mexp_pkg::t_dp_stat i_stat
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE_GO,
        S_REDUCE_WAIT,
        S_CHECK,
        S_MUL_WAIT,
        S_SQR_WAIT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.start     = 1'b0;
        o_cmd.op        = MM_REDUCE;
        o_cmd.shift_exp = 1'b0;
        o_finish        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE_GO;
                end
            end
            S_REDUCE_GO: begin
                if (i_stat.mod_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start = 1'b1;
                    n_state     = S_REDUCE_WAIT;
                end
            end
            S_REDUCE_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.start = !i_stat.exp_zero;
                o_cmd.op    = i_stat.exp_lsb ? MM_MUL : MM_SQR;
                if (i_stat.exp_zero) begin
                    n_state = S_FINISH;
                end else if (i_stat.exp_lsb) begin
                    n_state = S_MUL_WAIT;
                end else begin
                    n_state = S_SQR_WAIT;
                end
            end
            S_MUL_WAIT: begin
                o_cmd.op = MM_SQR;
                if (i_stat.mul_done) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SQR_WAIT;
                end
            end
            S_SQR_WAIT: begin
                if (i_stat.mul_done) begin
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_finish = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/modular_exponentiation_unit.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
//  beat          dir  tdata (low to high)                tuser
//  s_axis        in   base_value, exponent, modulus      -
//  m_axis        out  power_result                       zero_modulus_error
//
// One item at a time; all products go through one bit-serial modular
// multiplier. Reduction of the base is one pass, then each exponent bit
// costs a check step plus a multiply pass when the bit is set plus a
// squaring pass. A zero modulus skips all passes and goes from the reduce
// step straight to the finish state. Reset is synchronous, active low; no
// clearing pass. A stalled result sits in the output register while the
// next item is already taken.
`include "modular_exponentiation_unit_assert.svh"

module modular_exponentiation_unit #(
    parameter int unsigned WIDTH = mexp_pkg::MEXP_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // base_value, exponent, modulus
    input  logic [((3*WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // power_result
    output logic [((WIDTH+7)/8)*8-1:0]        o_m_axis_tdata,
    // zero_modulus_error
    output logic                              o_m_axis_tuser
);
    import mexp_pkg::*;

    localparam int unsigned OUT_W = ((WIDTH + 7) / 8) * 8;

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic             w_finish;
    logic             w_out_free;
    logic [WIDTH-1:0] w_power;

    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_out_err;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (w_out_free),
        .o_finish   (w_finish),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_base_value   (i_s_axis_tdata[WIDTH-1:0]),
        .i_exponent     (i_s_axis_tdata[2*WIDTH-1:WIDTH]),
        .i_modulus      (i_s_axis_tdata[3*WIDTH-1:2*WIDTH]),
        .o_power_result (w_power)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_data <= w_stat.mod_zero ? '0 : w_power;
            r_out_err  <= w_stat.mod_zero;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'(r_out_data);
    assign o_m_axis_tuser  = r_out_err;

    `MEU_ASSERT_SAME(a_finish_room, w_finish, !r_out_valid || i_m_axis_tready, "result overwritten")
    `MEU_ASSERT_NEXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "beat taken while busy")
    `MEU_ASSERT_SAME(a_err_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "error result not zero")

endmodule
